// ===== rtl/dsl_pkg.sv =====
// Package for the decimating sample log: sizes, command codes and item types.
`timescale 1ns / 1ps
`default_nettype none
package dsl_pkg;

    localparam int LOG_DEPTH = 128;
    localparam int IDX_W     = $clog2(LOG_DEPTH);
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int KEEP      = LOG_DEPTH / 2;
    localparam int J_W       = (KEEP > 1) ? $clog2(KEEP) : 1;

    localparam logic [15:0] BASE_PERIOD_RESET = 16'd500;
    localparam logic [15:0] EMPTY_MIN         = 16'hFFFF;
    localparam logic [31:0] PERIOD_MAX        = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] sample_voltage;
        logic [15:0] sample_current;
        logic [6:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [15:0] read_voltage;
        logic [15:0] read_current;
        logic        read_valid;
        logic [7:0]  entry_count;
        logic [31:0] period_ms;
        logic [15:0] lowest_mv;
        logic [15:0] highest_mv;
        logic        sample_dropped;
    } out_item_t;

    typedef struct packed {
        logic [15:0] current;
        logic [15:0] voltage;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic cmp_step;
        logic cmp_last;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_compact;
        logic cmp_final;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/dsl_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dsl_ctrl.sv =====
// Controller state machine: accept, compaction walk and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module dsl_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dsl_pkg::dp_status_t status,
    output dsl_pkg::ctrl_cmd_t       cmd
);
    import dsl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.accept   = 1'b0;
        cmd.cmp_step = 1'b0;
        cmd.cmp_last = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE: begin
                // take no request while reset is held
                s_ready    = aresetn;
                cmd.accept = s_valid && aresetn;
                if (s_valid) begin
                    state_next = status.need_compact ? S_CMP : S_DONE;
                end
            end
            S_CMP: begin
                cmd.cmp_step = 1'b1;
                if (status.cmp_final) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                cmd.cmp_last = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dsl_datapath.sv =====
// Datapath: log store, count, period, voltage extremes and result register.
`timescale 1ns / 1ps
`default_nettype none
module dsl_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dsl_pkg::in_item_t   s_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dsl_pkg::out_item_t       m_data,
    input  wire dsl_pkg::ctrl_cmd_t  cmd,
    output dsl_pkg::dp_status_t      status
);
    import dsl_pkg::*;

    logic [15:0]      base_reg;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [31:0]      period_reg, period_next;
    logic [15:0]      lo_reg,     lo_next;
    logic [15:0]      hi_reg,     hi_next;
    logic             rvalid_reg, rvalid_next;
    logic             drop_reg,   drop_next;
    logic [J_W-1:0]   j_reg,      j_next;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             note_en;
    logic [15:0]      note_v;

    assign cfg_ready = aresetn;
    assign full      = (count_reg == CNT_W'(LOG_DEPTH));

    assign status.need_compact = (s_data.cmd == CMD_ADD) && full;
    assign status.cmp_final    = (j_reg == J_W'(KEEP - 1));
    assign status.out_free     = !m_valid_reg || m_ready;

    dsl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // store port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[IDX_W-1:0];
        wr_data = entry_t'({s_data.sample_current, s_data.sample_voltage});
        rd_en   = 1'b0;
        rd_addr = IDX_W'(s_data.read_index);
        if (cmd.accept) begin
            wr_en = (s_data.cmd == CMD_ADD) && !full;
            rd_en = (s_data.cmd == CMD_READ);
        end else if (cmd.cmp_step) begin
            // read entry 2j, write back the survivor fetched last cycle
            rd_en   = 1'b1;
            rd_addr = IDX_W'({j_reg, 1'b0});
            wr_en   = (j_reg != '0);
            wr_addr = IDX_W'(j_reg - J_W'(1));
            wr_data = rd_data;
        end else if (cmd.cmp_last) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(j_reg);
            wr_data = rd_data;
        end
    end

    always_comb begin
        count_next  = count_reg;
        period_next = period_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        rvalid_next = rvalid_reg;
        drop_next   = drop_reg;
        j_next      = j_reg;
        note_en     = 1'b0;
        note_v      = rd_data.voltage;
        if (cmd.accept) begin
            rvalid_next = 1'b0;
            drop_next   = 1'b0;
            j_next      = '0;
            case (s_data.cmd)
                CMD_ADD: begin
                    if (full) begin
                        period_next = (period_reg > (PERIOD_MAX >> 1)) ? PERIOD_MAX
                                                                       : {period_reg[30:0], 1'b0};
                        lo_next     = EMPTY_MIN;
                        hi_next     = '0;
                        count_next  = CNT_W'(KEEP);
                        drop_next   = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                        note_en    = 1'b1;
                        note_v     = s_data.sample_voltage;
                    end
                end
                CMD_READ: begin
                    rvalid_next = (CNT_W'(s_data.read_index) < count_reg);
                end
                CMD_CLEAR: begin
                    count_next  = '0;
                    period_next = 32'(base_reg);
                    lo_next     = EMPTY_MIN;
                    hi_next     = '0;
                end
                default: begin
                end
            endcase
        end else if (cmd.cmp_step) begin
            if (j_reg != J_W'(KEEP - 1)) begin
                j_next = j_reg + J_W'(1);
            end
            note_en = (j_reg != '0);
        end else if (cmd.cmp_last) begin
            note_en = 1'b1;
        end
        if (note_en) begin
            if (note_v < lo_reg) begin
                lo_next = note_v;
            end
            if (note_v > hi_reg) begin
                hi_next = note_v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= BASE_PERIOD_RESET;
            count_reg   <= '0;
            period_reg  <= 32'(BASE_PERIOD_RESET);
            lo_reg      <= EMPTY_MIN;
            hi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                base_reg <= cfg_data;
            end
            count_reg  <= count_next;
            period_reg <= period_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rvalid_reg <= rvalid_next;
        drop_reg   <= drop_next;
        j_reg      <= j_next;
        if (cmd.out_load) begin
            m_data_reg.read_voltage   <= rvalid_reg ? rd_data.voltage : 16'd0;
            m_data_reg.read_current   <= rvalid_reg ? rd_data.current : 16'd0;
            m_data_reg.read_valid     <= rvalid_reg;
            m_data_reg.entry_count    <= 8'(count_reg);
            m_data_reg.period_ms      <= period_reg;
            m_data_reg.lowest_mv      <= lo_reg;
            m_data_reg.highest_mv     <= hi_reg;
            m_data_reg.sample_dropped <= drop_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/decimating_sample_log.sv =====
// Top level of the decimating sample log.
//
//  channel | ports                         | direction | moves
//  --------+-------------------------------+-----------+--------------------------
//  input   | s_valid s_ready s_data        | in        | add / read / clear request
//  result  | m_valid m_ready m_data        | out       | one result per request
//  config  | cfg_valid cfg_ready cfg_data  | in        | base period write
//
// Add, read, clear and unused requests go from accept to result load. An add into a full
// log runs the compaction walk in between, through the single write port of the store,
// one survivor a cycle.
// A request is accepted while an earlier result waits in the output register; its own
// result then holds until that register is taken. On reset the store is not cleared;
// the count marks which entries hold data.
`timescale 1ns / 1ps
`default_nettype none
module decimating_sample_log (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dsl_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dsl_pkg::out_item_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);
    import dsl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dsl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dsl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

// ===== rtl/dsl_checker.sv =====
// Port-level checker for the decimating sample log, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dsl_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire dsl_pkg::out_item_t m_data
);
    import dsl_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.entry_count == 8'd0 |->
            m_data.lowest_mv == EMPTY_MIN && m_data.highest_mv == 16'd0)
        else $error("empty log reports voltage extremes");

    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.sample_dropped |->
            m_data.entry_count == 8'(KEEP) && !m_data.read_valid)
        else $error("dropped request with wrong count");

    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.read_valid |->
            m_data.read_voltage == 16'd0 && m_data.read_current == 16'd0)
        else $error("read fields set without a valid read");

endmodule

bind decimating_sample_log dsl_checker u_dsl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
